>>> rtl/dfu_pkg.sv
// Shared constants, codes and types for the DFU request state machine.
// No dependencies; imported by the controller, the datapath and the top level.
package dfu_pkg;

    localparam int TRANSFER_SIZE = 1024;
    localparam int PAGE_SIZE     = 1024;
    localparam int MAX_ERASE     = 4;

    localparam int LEN_W    = $clog2(TRANSFER_SIZE + 1);
    localparam int ERASE_W  = $clog2(MAX_ERASE + 1);
    localparam int BYTE_W   = 11;
    localparam int KB_SHIFT = 10;

    localparam logic [31:0] FLASH_BASE_RST = 32'h0800_0000;
    localparam logic [10:0] BOOT_RES_RST   = 11'd8;
    localparam logic [10:0] FLASH_KB_RST   = 11'd128;
    localparam logic [23:0] POLL_MS        = 24'd100;
    localparam logic [BYTE_W-1:0] CMDLIST_LEN = BYTE_W'(3);
    localparam logic [31:0] XFER32  = 32'(TRANSFER_SIZE);
    localparam logic [32:0] PAGE33  = 33'(PAGE_SIZE);

    // request codes
    localparam logic [3:0] CMD_DNLOAD    = 4'd0;
    localparam logic [3:0] CMD_UPLOAD    = 4'd1;
    localparam logic [3:0] CMD_GETSTATUS = 4'd2;
    localparam logic [3:0] CMD_CLRSTATUS = 4'd3;
    localparam logic [3:0] CMD_GETSTATE  = 4'd4;
    localparam logic [3:0] CMD_ABORT     = 4'd5;
    localparam logic [3:0] CMD_DETACH    = 4'd6;
    localparam logic [3:0] CMD_COMPLETE  = 4'd7;

    // DFU protocol states, specification numbering
    localparam logic [3:0] DFU_IDLE     = 4'd2;
    localparam logic [3:0] DFU_DNSYNC   = 4'd3;
    localparam logic [3:0] DFU_DNBUSY   = 4'd4;
    localparam logic [3:0] DFU_DNIDLE   = 4'd5;
    localparam logic [3:0] DFU_MANSYNC  = 4'd6;
    localparam logic [3:0] DFU_MANIFEST = 4'd7;
    localparam logic [3:0] DFU_UPIDLE   = 4'd9;
    localparam logic [3:0] DFU_ERROR    = 4'd10;

    // block-zero vendor commands
    localparam logic [7:0] OP_SETADDR = 8'h21;
    localparam logic [7:0] OP_ERASE   = 8'h41;

    // result actions
    localparam logic [3:0] ACT_STATUS  = 4'd0;
    localparam logic [3:0] ACT_STATE   = 4'd1;
    localparam logic [3:0] ACT_CMDLIST = 4'd2;
    localparam logic [3:0] ACT_UPREAD  = 4'd3;
    localparam logic [3:0] ACT_EMPTY   = 4'd4;
    localparam logic [3:0] ACT_PASS    = 4'd5;
    localparam logic [3:0] ACT_ERASE   = 4'd6;
    localparam logic [3:0] ACT_PROGRAM = 4'd7;
    localparam logic [3:0] ACT_DONE    = 4'd8;

    // configuration register indexes
    localparam logic [7:0] CFG_FLASH_BASE = 8'd0;
    localparam logic [7:0] CFG_BOOT_RES   = 8'd1;
    localparam logic [7:0] CFG_FLASH_KB   = 8'd2;
    localparam logic [7:0] CFG_ALT_PROG   = 8'd3;
    localparam logic [7:0] CFG_UPLOAD_EN  = 8'd4;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_OFFSET,
        CS_BASE,
        CS_CHECK,
        CS_COMMIT,
        CS_ERASE,
        CS_PROG,
        CS_LAST
    } ctrl_state_t;

    typedef struct packed {
        logic load_item;
        logic calc_offset;
        logic calc_base;
        logic calc_check;
        logic commit;
        logic emit_erase;
        logic emit_prog;
        logic emit_last;
    } dp_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic erase_more;
        logic prog_pending;
    } dp_status_t;

endpackage

>>> rtl/dfu_request_state_machine_unit.sv
// DFU request state machine, top level: controller plus datapath.
// One request at a time: accept, offset, base, window check, commit, then
// one result per free output slot: any erase pages, a program, then the final
// result. The fixed offset/base/check/commit sequence sets the pace.
// Reset (rst_n, async low) gives dfuIDLE, cleared pointers and default config.
module dfu_request_state_machine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  command,
    input  logic [15:0] block_num,
    input  logic [15:0] length,
    input  logic [7:0]  payload_cmd,
    input  logic [31:0] payload_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  action,
    output logic [31:0] flash_addr,
    output logic [10:0] byte_count,
    output logic        use_alt_program,
    output logic        status_code,
    output logic [23:0] poll_timeout,
    output logic [3:0]  dev_state,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import dfu_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    dfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    dfu_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .command         (command),
        .block_num       (block_num),
        .length          (length),
        .payload_cmd     (payload_cmd),
        .payload_word    (payload_word),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .action          (action),
        .flash_addr      (flash_addr),
        .byte_count      (byte_count),
        .use_alt_program (use_alt_program),
        .status_code     (status_code),
        .poll_timeout    (poll_timeout),
        .dev_state       (dev_state),
        .last            (last)
    );

    // a result is only loaded into a free output slot
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_erase || cmd.emit_prog || cmd.emit_last) |-> status.slot_free)
        else $error("result loaded while output slot occupied");

    a_emit_one: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_erase, cmd.emit_prog, cmd.emit_last}))
        else $error("more than one result loaded in a cycle");

    // one transaction in flight: no new request right after acceptance
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while previous one in progress");

    a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(cmd.emit_erase || cmd.emit_prog || cmd.emit_last))
        else $error("result loaded with no request in progress");

endmodule

>>> rtl/dfu_ctrl.sv
// Sequencing controller: walks one request through address, window check,
// commit and result emission. Depends on dfu_pkg.
module dfu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output dfu_pkg::dp_cmd_t    cmd,
    input  dfu_pkg::dp_status_t status
);
    import dfu_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = CS_OFFSET;
                end
            end
            CS_OFFSET:
            begin
                cmd.calc_offset = 1'b1;
                state_next      = CS_BASE;
            end
            CS_BASE:
            begin
                cmd.calc_base = 1'b1;
                state_next    = CS_CHECK;
            end
            CS_CHECK:
            begin
                cmd.calc_check = 1'b1;
                state_next     = CS_COMMIT;
            end
            CS_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = CS_ERASE;
            end
            CS_ERASE:
            begin
                // one erase per free slot; counters advance in the datapath
                if (status.erase_more)
                begin
                    cmd.emit_erase = status.slot_free;
                end
                else if (status.prog_pending)
                begin
                    state_next = CS_PROG;
                end
                else
                begin
                    state_next = CS_LAST;
                end
            end
            CS_PROG:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_prog = 1'b1;
                    state_next    = CS_LAST;
                end
            end
            CS_LAST:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_last = 1'b1;
                    state_next    = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/dfu_datapath.sv
// Datapath: configuration and protocol registers, block address and window
// arithmetic, erase page walker and the result output register. Uses dfu_pkg.
module dfu_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dfu_pkg::dp_cmd_t     cmd,
    output dfu_pkg::dp_status_t  status,
    input  logic [3:0]           command,
    input  logic [15:0]          block_num,
    input  logic [15:0]          length,
    input  logic [7:0]           payload_cmd,
    input  logic [31:0]          payload_word,
    input  logic                 cfg_valid,
    input  logic [7:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3:0]           action,
    output logic [31:0]          flash_addr,
    output logic [10:0]          byte_count,
    output logic                 use_alt_program,
    output logic                 status_code,
    output logic [23:0]          poll_timeout,
    output logic [3:0]           dev_state,
    output logic                 last
);
    import dfu_pkg::*;

    // configuration
    logic [31:0] flash_base_reg;
    logic [10:0] boot_res_reg;
    logic [10:0] flash_kb_reg;
    logic        alt_prog_reg;
    logic        upload_en_reg;

    // protocol state
    logic [3:0]       proto_reg, proto_next;
    logic [15:0]      sv_block_reg;
    logic [LEN_W-1:0] sv_len_reg;
    logic [7:0]       sv_cmd_reg;
    logic [31:0]      sv_word_reg;
    logic [31:0]      ptr_reg, ptr_next;
    logic             save_en;

    // current request
    logic [3:0]  it_cmd_reg;
    logic [15:0] it_blk_reg;
    logic [15:0] it_len_reg;
    logic [7:0]  it_pcmd_reg;
    logic [31:0] it_word_reg;

    // address pipeline
    logic [32:0]      lo_reg, hi_reg;
    logic [31:0]      off_reg, base_reg;
    logic [LEN_W-1:0] len_reg;
    logic             ok_reg;
    logic [32:0]      page_reg, stop_reg;
    logic [ERASE_W-1:0] ecnt_reg;
    logic             job_reg, job_next;
    logic             single_reg, single_next;

    // final result of the request
    logic [3:0]        fin_act_reg, fin_act_next;
    logic [31:0]       fin_addr_reg, fin_addr_next;
    logic [BYTE_W-1:0] fin_cnt_reg, fin_cnt_next;
    logic              fin_code_reg, fin_code_next;
    logic [23:0]       fin_poll_reg, fin_poll_next;

    // output register
    logic              ov_reg;
    logic [3:0]        o_act_reg;
    logic [31:0]       o_addr_reg;
    logic [BYTE_W-1:0] o_cnt_reg;
    logic              o_alt_reg;
    logic              o_code_reg;
    logic [23:0]       o_poll_reg;
    logic [3:0]        o_state_reg;
    logic              o_last_reg;

    logic [15:0]      blk_sel;
    logic [31:0]      blk_m2;
    logic [32:0]      range_end;
    logic [LEN_W-1:0] len_clamp;
    logic [ERASE_W-1:0] ecnt_limit;
    logic             emit_any;

    assign blk_sel  = (it_cmd_reg == CMD_UPLOAD) ? it_blk_reg : sv_block_reg;
    assign blk_m2   = {16'b0, blk_sel} - 32'd2;
    assign range_end = {1'b0, base_reg} + 33'(len_reg);
    assign len_clamp = (it_len_reg > 16'(TRANSFER_SIZE)) ? LEN_W'(TRANSFER_SIZE)
                                                         : it_len_reg[LEN_W-1:0];
    assign ecnt_limit = single_reg ? ERASE_W'(1) : ERASE_W'(MAX_ERASE);
    assign emit_any   = cmd.emit_erase | cmd.emit_prog | cmd.emit_last;

    assign status.slot_free    = !ov_reg || out_ready;
    assign status.erase_more   = job_reg && (page_reg < stop_reg) && (ecnt_reg < ecnt_limit);
    assign status.prog_pending = job_reg && !single_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_base_reg <= FLASH_BASE_RST;
            boot_res_reg   <= BOOT_RES_RST;
            flash_kb_reg   <= FLASH_KB_RST;
            alt_prog_reg   <= 1'b0;
            upload_en_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FLASH_BASE: flash_base_reg <= cfg_data;
                CFG_BOOT_RES:   boot_res_reg   <= cfg_data[10:0];
                CFG_FLASH_KB:   flash_kb_reg   <= cfg_data[10:0];
                CFG_ALT_PROG:   alt_prog_reg   <= cfg_data[0];
                CFG_UPLOAD_EN:  upload_en_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // window bounds, no wrap
    always_ff @(posedge clk)
    begin
        lo_reg <= {1'b0, flash_base_reg} + {12'b0, boot_res_reg, 10'b0};
        hi_reg <= {1'b0, flash_base_reg} + {12'b0, flash_kb_reg, 10'b0};
    end

    // request commit: new protocol state and the final result
    always_comb
    begin
        proto_next    = proto_reg;
        ptr_next      = ptr_reg;
        save_en       = 1'b0;
        job_next      = 1'b0;
        single_next   = 1'b0;
        fin_act_next  = ACT_EMPTY;
        fin_addr_next = '0;
        fin_cnt_next  = '0;
        fin_code_next = 1'b0;
        fin_poll_next = '0;
        unique case (it_cmd_reg)
            CMD_DNLOAD:
            begin
                if (it_len_reg == 16'd0)
                begin
                    proto_next = DFU_MANSYNC;
                end
                else
                begin
                    save_en    = 1'b1;
                    proto_next = DFU_DNSYNC;
                end
            end
            CMD_UPLOAD:
            begin
                proto_next = DFU_UPIDLE;
                if (it_blk_reg == 16'd0)
                begin
                    fin_act_next = ACT_CMDLIST;
                    fin_cnt_next = CMDLIST_LEN;
                end
                else if (!upload_en_reg || !ok_reg)
                begin
                    proto_next = DFU_ERROR;
                end
                else
                begin
                    fin_act_next  = ACT_UPREAD;
                    fin_addr_next = base_reg;
                    fin_cnt_next  = BYTE_W'(TRANSFER_SIZE);
                end
            end
            CMD_GETSTATUS:
            begin
                fin_act_next = ACT_STATUS;
                if (proto_reg == DFU_DNSYNC)
                begin
                    proto_next    = DFU_DNBUSY;
                    fin_poll_next = POLL_MS;
                end
                else if (proto_reg == DFU_MANSYNC)
                begin
                    proto_next = DFU_MANIFEST;
                end
                else if (proto_reg == DFU_ERROR)
                begin
                    fin_code_next = 1'b1;
                end
            end
            CMD_CLRSTATUS:
            begin
                if (proto_reg == DFU_ERROR)
                begin
                    proto_next = DFU_IDLE;
                end
            end
            CMD_GETSTATE:
            begin
                fin_act_next = ACT_STATE;
            end
            CMD_ABORT:
            begin
                proto_next = DFU_IDLE;
            end
            CMD_DETACH:
            begin
                proto_next = DFU_MANIFEST;
            end
            CMD_COMPLETE:
            begin
                fin_act_next = ACT_DONE;
                if (proto_reg == DFU_DNBUSY)
                begin
                    proto_next = DFU_DNIDLE;
                    if (sv_block_reg == 16'd0)
                    begin
                        single_next = 1'b1;
                        job_next    = (sv_cmd_reg == OP_ERASE) && ok_reg;
                        if (sv_cmd_reg == OP_SETADDR)
                        begin
                            ptr_next = sv_word_reg;
                        end
                    end
                    else
                    begin
                        job_next = ok_reg;
                    end
                end
            end
            default:
            begin
                fin_act_next = ACT_PASS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proto_reg    <= DFU_IDLE;
            sv_block_reg <= '0;
            sv_len_reg   <= '0;
            sv_cmd_reg   <= '0;
            sv_word_reg  <= '0;
            ptr_reg      <= '0;
            job_reg      <= 1'b0;
            single_reg   <= 1'b0;
            ecnt_reg     <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                proto_reg  <= proto_next;
                ptr_reg    <= ptr_next;
                job_reg    <= job_next;
                single_reg <= single_next;
                ecnt_reg   <= '0;
                if (save_en)
                begin
                    sv_block_reg <= it_blk_reg;
                    sv_len_reg   <= len_clamp;
                    sv_cmd_reg   <= it_pcmd_reg;
                    sv_word_reg  <= it_word_reg;
                end
            end
            if (cmd.emit_erase)
            begin
                ecnt_reg <= ecnt_reg + ERASE_W'(1);
            end
            if (cmd.emit_last)
            begin
                job_reg <= 1'b0;
            end
            if (emit_any)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            it_cmd_reg  <= command;
            it_blk_reg  <= block_num;
            it_len_reg  <= length;
            it_pcmd_reg <= payload_cmd;
            it_word_reg <= payload_word;
        end
        if (cmd.calc_offset)
        begin
            off_reg <= blk_m2 * XFER32;
        end
        if (cmd.calc_base)
        begin
            // block-zero erase checks its own address over one transfer
            if (it_cmd_reg == CMD_COMPLETE && sv_block_reg == 16'd0)
            begin
                base_reg <= sv_word_reg;
                len_reg  <= LEN_W'(TRANSFER_SIZE);
            end
            else
            begin
                base_reg <= ptr_reg + off_reg;
                len_reg  <= (it_cmd_reg == CMD_COMPLETE) ? sv_len_reg
                                                         : LEN_W'(TRANSFER_SIZE);
            end
        end
        if (cmd.calc_check)
        begin
            ok_reg   <= ({1'b0, base_reg} >= lo_reg) && (range_end <= hi_reg);
            stop_reg <= range_end;
            page_reg <= {1'b0, base_reg};
        end
        if (cmd.commit)
        begin
            fin_act_reg  <= fin_act_next;
            fin_addr_reg <= fin_addr_next;
            fin_cnt_reg  <= fin_cnt_next;
            fin_code_reg <= fin_code_next;
            fin_poll_reg <= fin_poll_next;
        end
        if (cmd.emit_erase)
        begin
            page_reg <= page_reg + PAGE33;
        end
        if (emit_any)
        begin
            o_state_reg <= proto_reg;
            if (cmd.emit_erase)
            begin
                o_act_reg  <= ACT_ERASE;
                o_addr_reg <= page_reg[31:0];
                o_cnt_reg  <= '0;
                o_alt_reg  <= 1'b0;
                o_code_reg <= 1'b0;
                o_poll_reg <= '0;
                o_last_reg <= 1'b0;
            end
            else if (cmd.emit_prog)
            begin
                o_act_reg  <= ACT_PROGRAM;
                o_addr_reg <= base_reg;
                o_cnt_reg  <= BYTE_W'(len_reg);
                o_alt_reg  <= alt_prog_reg;
                o_code_reg <= 1'b0;
                o_poll_reg <= '0;
                o_last_reg <= 1'b0;
            end
            else
            begin
                o_act_reg  <= fin_act_reg;
                o_addr_reg <= fin_addr_reg;
                o_cnt_reg  <= fin_cnt_reg;
                o_alt_reg  <= 1'b0;
                o_code_reg <= fin_code_reg;
                o_poll_reg <= fin_poll_reg;
                o_last_reg <= 1'b1;
            end
        end
    end

    assign out_valid       = ov_reg;
    assign action          = o_act_reg;
    assign flash_addr      = o_addr_reg;
    assign byte_count      = o_cnt_reg;
    assign use_alt_program = o_alt_reg;
    assign status_code     = o_code_reg;
    assign poll_timeout    = o_poll_reg;
    assign dev_state       = o_state_reg;
    assign last            = o_last_reg;

endmodule
